// ===== rtl/srtf_pkg.sv =====
// shared types and constants for the static route table forwarder
package srtf_pkg;

  localparam int MAX_ROUTES_DEF = 16;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic REG_GATEWAY = 1'b0;
  localparam logic REG_BCAST = 1'b1;

  typedef enum logic [1:0] {
    CMD_ROUTE = 2'd0,
    CMD_ADD = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_DELIVER = 3'd0,
    ACT_SEND = 3'd1,
    ACT_DROP = 3'd2,
    ACT_STORED = 3'd3,
    ACT_FULL = 3'd4,
    ACT_INVALID = 3'd5,
    ACT_CLEARED = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] dest_addr;
    logic [7:0] route_next_hop;
    logic [7:0] packet_next_hop;
    logic       direction_up;
  } req_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] next_hop_out;
    logic [4:0] route_count;
  } rsp_t;

  typedef struct packed {
    logic       en;
    logic       clr;
    logic [7:0] key;
    logic [7:0] hop;
  } tbl_wr_t;

  typedef struct packed {
    logic [7:0] key;
    logic [7:0] hop;
    logic       vld;
  } tbl_rd_t;

endpackage

// ===== rtl/static_route_table_forwarder.sv =====
// static route table forwarder top level: sequencer, scan compare and registers
//
// one request on in_data per in_valid/in_stall handshake, one result per request
// on out_data (a request with an unused command code gives no result)
// route and add requests scan the table one entry per cycle through a single
// 8-bit key comparator; the result is registered after the scan, last and done
// steps of the sequencer, and the next request is taken only once the
// sequencer is back in idle, after the result has been loaded
// clear requests go from acceptance straight to the done step with no scan, as
// do unused command codes; the scan length of the table sets the rate
// in_stall is high from acceptance until the result is loaded into the
// output register, so the next request may enter while a result waits
// a stalled result holds out_data; a later result then waits in the
// sequencer's final step, with in_stall high, until the output register frees
// registers on the apb port: gateway at 0x0, broadcast address at 0x4
// synchronous reset empties the table, clears the count and any pending
// result, and sets the gateway to 0 and the broadcast address to 255
module static_route_table_forwarder import srtf_pkg::*; #(
  parameter int MAX_ROUTES = MAX_ROUTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  req_t              in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rsp_t              out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int IDX_W = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
  localparam int CNT_W = $clog2(MAX_ROUTES + 1);

  state_t           state, state_next;
  req_t             req;
  logic [7:0]       gateway, bcast;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] scan_idx, rd_idx, hit_idx, free_idx;
  logic             rd_pend, hit, free_found;
  logic [7:0]       hit_hop;
  tbl_rd_t          rd;
  tbl_wr_t          wr;
  logic [IDX_W-1:0] wr_idx;
  logic             accept, load, out_busy, cmd_known, key_eq;
  rsp_t             rsp;
  logic [7:0]       hop_sel;
  logic [31:0]      count_ext;

  assign accept = in_valid && !in_stall;
  assign out_busy = out_valid && out_stall;
  assign cmd_known = (req.command == CMD_ROUTE) || (req.command == CMD_ADD) ||
                     (req.command == CMD_CLEAR);
  assign key_eq = (rd.key == req.dest_addr);

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BCAST) ? {24'd0, bcast} : {24'd0, gateway};

  always_ff @(posedge clk) begin
    if (rst) begin
      gateway <= 8'd0;
      bcast <= 8'd255;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_BCAST) begin
        bcast <= pwdata[7:0];
      end else begin
        gateway <= pwdata[7:0];
      end
    end
  end

  srtf_table #(
    .MAX_ROUTES(MAX_ROUTES),
    .IDX_W(IDX_W)
  ) u_table (
    .clk(clk),
    .rst(rst),
    .rd_addr(scan_idx),
    .rd(rd),
    .wr_idx(wr_idx),
    .wr(wr)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if ((in_data.command == CMD_ROUTE) || (in_data.command == CMD_ADD)) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (scan_idx == IDX_W'(MAX_ROUTES - 1)) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST: state_next = ST_DONE;
      ST_DONE: begin
        if (!cmd_known || !out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
    load = (state == ST_DONE) && cmd_known && !out_busy;
    hop_sel = hit ? hit_hop : gateway;
    wr = '0;
    wr.key = req.dest_addr;
    wr.hop = req.route_next_hop;
    wr_idx = hit ? hit_idx : free_idx;
    count_next = count;
    rsp.action = ACT_CLEARED;
    rsp.next_hop_out = 8'd0;
    case (req.command)
      CMD_ROUTE: begin
        if (req.direction_up &&
            ((req.dest_addr == req.packet_next_hop) || (req.dest_addr == bcast))) begin
          rsp.action = ACT_DELIVER;
        end else if (hop_sel == 8'd0) begin
          rsp.action = ACT_DROP;
        end else begin
          rsp.action = ACT_SEND;
          rsp.next_hop_out = hop_sel;
        end
      end
      CMD_ADD: begin
        if ((req.dest_addr == 8'd0) || (req.route_next_hop == 8'd0)) begin
          rsp.action = ACT_INVALID;
        end else if (hit) begin
          rsp.action = ACT_STORED;
          wr.en = load;
        end else if ((count == CNT_W'(MAX_ROUTES)) || !free_found) begin
          rsp.action = ACT_FULL;
        end else begin
          rsp.action = ACT_STORED;
          wr.en = load;
          count_next = count + CNT_W'(1);
        end
      end
      CMD_CLEAR: begin
        rsp.action = ACT_CLEARED;
        wr.clr = load;
        count_next = '0;
      end
      default: begin
        rsp.action = ACT_CLEARED;
      end
    endcase
    count_ext = 32'(count_next);
    rsp.route_count = count_ext[4:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      out_valid <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      state <= state_next;
      rd_pend <= (state == ST_SCAN);
      if (load) begin
        count <= count_next;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // scan address and single shared key compare
  always_ff @(posedge clk) begin
    if (accept) begin
      req <= in_data;
      scan_idx <= '0;
      hit <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (state == ST_SCAN) begin
        rd_idx <= scan_idx;
        scan_idx <= scan_idx + IDX_W'(1);
      end
      if (rd_pend) begin
        if (rd.vld && key_eq && !hit) begin
          hit <= 1'b1;
          hit_idx <= rd_idx;
          hit_hop <= rd.hop;
        end
        if (!rd.vld && !free_found) begin
          free_found <= 1'b1;
          free_idx <= rd_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.action <= rsp.action;
      out_data.next_hop_out <= rsp.next_hop_out;
      out_data.route_count <= rsp.route_count;
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("request taken while a previous one is in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ROUTES))
    else $error("route count exceeds table size");

  a_send_hop: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.action == ACT_SEND) |-> (out_data.next_hop_out != 8'd0))
    else $error("packet sent with zero next hop");

  a_other_hop: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.action != ACT_SEND) |-> (out_data.next_hop_out == 8'd0))
    else $error("next hop set on a result that is not a send");
`endif

endmodule

// ===== rtl/srtf_table.sv =====
// route table storage: key and hop memory with per-entry valid flags
module srtf_table import srtf_pkg::*; #(
  parameter int MAX_ROUTES = MAX_ROUTES_DEF,
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] rd_addr,
  output tbl_rd_t          rd,
  input  logic [IDX_W-1:0] wr_idx,
  input  tbl_wr_t          wr
);

  logic [7:0]            key_mem [MAX_ROUTES];
  logic [7:0]            hop_mem [MAX_ROUTES];
  logic [MAX_ROUTES-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      key_mem[wr_idx] <= wr.key;
      hop_mem[wr_idx] <= wr.hop;
    end
    rd.key <= key_mem[rd_addr];
    rd.hop <= hop_mem[rd_addr];
    rd.vld <= valid[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || wr.clr) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr_idx] <= 1'b1;
    end
  end

endmodule
